// ----- design/ahdsr_pkg.sv -----
// Shared types and constants for the AHDSR envelope generator.
// Used by ahdsr_muldiv, ahdsr_seq and ahdsr_envelope_generator.
`timescale 1ns / 1ps
package ahdsr_pkg;

  localparam int unsigned TIME_BITS_DEF = 24;
  localparam int unsigned LEVEL_W       = 16;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_HOLD    = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4,
    PH_IDLE    = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_HOLD    = 3'd1,
    CFG_DECAY   = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_RELEASE = 3'd4,
    CFG_CURVE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EVAL,
    SQ_RAMP,
    SQ_SQR,
    SQ_SCALE,
    SQ_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIX
  } md_state_e;

  typedef struct packed {
    logic start_note;
    logic key_released;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_e             phase;
  } out_word_t;

endpackage

// ----- design/ahdsr_muldiv.sv -----
// Shared multiply-divide unit: quot = a * b / den, quotient below 2^16.
// Restoring divider, one quotient bit per cycle; divide by full scale in one step.
// Depends on ahdsr_pkg.
`timescale 1ns / 1ps
module ahdsr_muldiv
  import ahdsr_pkg::*;
#(
  parameter int unsigned OP_W = TIME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               by_full_i,
  input  logic [OP_W-1:0]    a_i,
  input  logic [LEVEL_W-1:0] b_i,
  input  logic [OP_W-1:0]    den_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] quot_o
);

  localparam int unsigned PROD_W = OP_W + LEVEL_W;
  localparam int unsigned CNT_W  = $clog2(LEVEL_W);

  md_state_e state_q, state_d;
  logic                done_q, done_d;
  logic [OP_W-1:0]     a_q, den_q, rem_q, rem_d;
  logic [LEVEL_W-1:0]  b_q, quot_q, quot_d;
  logic                full_q;
  logic [PROD_W-1:0]   prod_q, mul_w;
  logic [LEVEL_W-1:0]  prod_lo_w;
  logic [CNT_W-1:0]    cnt_q;
  logic [OP_W:0]       trial_w, diff_w;
  logic                fits_w;
  logic [LEVEL_W-1:0]  fix_hi_w, fix_quot_w;
  logic [LEVEL_W:0]    fix_r_w;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  state_d = full_q ? MD_FIX : MD_DIV;
      MD_FIX:  state_d = MD_IDLE;
      MD_DIV:  if (cnt_q == '0) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_comb begin
    mul_w      = PROD_W'(a_q) * PROD_W'(b_q);
    prod_lo_w  = prod_q[LEVEL_W-1:0];
    trial_w    = {rem_q, prod_lo_w[cnt_q]};
    diff_w     = trial_w - {1'b0, den_q};
    fits_w     = trial_w >= {1'b0, den_q};
    rem_d      = fits_w ? diff_w[OP_W-1:0] : trial_w[OP_W-1:0];
    quot_d     = {quot_q[LEVEL_W-2:0], fits_w};
    fix_hi_w   = prod_q[2*LEVEL_W-1:LEVEL_W];
    fix_r_w    = {1'b0, prod_lo_w} + {1'b0, fix_hi_w};
    fix_quot_w = (fix_r_w >= {1'b0, LEVEL_FULL}) ? fix_hi_w + LEVEL_W'(1) : fix_hi_w;
    done_d     = (state_q == MD_FIX) || ((state_q == MD_DIV) && (cnt_q == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          a_q    <= a_i;
          b_q    <= b_i;
          den_q  <= den_i;
          full_q <= by_full_i;
        end
      end
      MD_MUL: begin
        prod_q <= mul_w;
        rem_q  <= mul_w[PROD_W-1:LEVEL_W];
        cnt_q  <= CNT_W'(LEVEL_W - 1);
      end
      MD_DIV: begin
        rem_q  <= rem_d;
        quot_q <= quot_d;
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      MD_FIX: quot_q <= fix_quot_w;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- design/ahdsr_seq.sv -----
// Envelope sequencer: phase, elapsed counter, held level and output register.
// Drives the shared multiply-divide unit through ramp, square and scale steps.
// Depends on ahdsr_pkg.
`timescale 1ns / 1ps
module ahdsr_seq
  import ahdsr_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  parameter int unsigned OP_W      = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic [TIME_BITS-1:0] attack_i,
  input  logic [TIME_BITS-1:0] hold_i,
  input  logic [TIME_BITS-1:0] decay_i,
  input  logic [TIME_BITS-1:0] release_i,
  input  logic [LEVEL_W-1:0]   sustain_i,
  input  logic                 quad_i,
  output logic                 md_start_o,
  output logic                 md_by_full_o,
  output logic [OP_W-1:0]      md_a_o,
  output logic [LEVEL_W-1:0]   md_b_o,
  output logic [OP_W-1:0]      md_den_o,
  input  logic                 md_done_i,
  input  logic [LEVEL_W-1:0]   md_quot_i
);

  seq_state_e state_q, state_d;
  phase_e     phase_q, in_phase_w, eval_phase_w;
  logic [TIME_BITS-1:0] elapsed_q, seg_len_w;
  logic [LEVEL_W-1:0]   held_q, last_q, lvl_q, lvl_d, ramp_p_w, eval_lvl_w;
  logic [OP_W-1:0]      scale_a_w;
  logic                 held_we_q, in_zero_w, seg_end_w, ramp_w, lvl_we_w;
  logic                 accept_w, out_free_w, is_attack_w;
  logic                 out_valid_q;
  out_word_t            out_word_q;

  assign accept_w    = in_valid_i && (state_q == SQ_IDLE);
  assign out_free_w  = !out_valid_q || !out_stall_i;
  assign is_attack_w = phase_q == PH_ATTACK;

  // flags ahead of the phase evaluation
  always_comb begin
    in_phase_w = phase_q;
    in_zero_w  = 1'b0;
    if (in_word_i.start_note) begin
      in_phase_w = PH_ATTACK;
      in_zero_w  = 1'b1;
    end
    if (in_word_i.key_released && in_phase_w != PH_RELEASE && in_phase_w != PH_IDLE) begin
      in_phase_w = PH_RELEASE;
      in_zero_w  = 1'b1;
    end
  end

  always_comb begin
    unique case (phase_q)
      PH_ATTACK:  seg_len_w = attack_i;
      PH_HOLD:    seg_len_w = hold_i;
      PH_DECAY:   seg_len_w = decay_i;
      PH_RELEASE: seg_len_w = release_i;
      default:    seg_len_w = '0;
    endcase
    seg_end_w = (seg_len_w == '0) || (elapsed_q > seg_len_w);
    ramp_w    = !seg_end_w &&
                (phase_q == PH_ATTACK || phase_q == PH_DECAY || phase_q == PH_RELEASE);
  end

  // end-of-segment or flat level
  always_comb begin
    eval_phase_w = phase_q;
    eval_lvl_w   = last_q;
    unique case (phase_q)
      PH_ATTACK: begin
        eval_lvl_w = LEVEL_FULL;
        if (seg_end_w) eval_phase_w = PH_HOLD;
      end
      PH_HOLD: begin
        eval_lvl_w = LEVEL_FULL;
        if (seg_end_w) eval_phase_w = PH_DECAY;
      end
      PH_DECAY: begin
        eval_lvl_w = sustain_i;
        if (seg_end_w) eval_phase_w = PH_SUSTAIN;
      end
      PH_SUSTAIN: eval_lvl_w = sustain_i;
      PH_RELEASE: if (seg_end_w) eval_phase_w = PH_IDLE;
      default:    eval_phase_w = PH_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: if (in_valid_i) state_d = SQ_EVAL;
      SQ_EVAL: state_d = ramp_w ? SQ_RAMP : SQ_OUT;
      SQ_RAMP: begin
        if (md_done_i) begin
          if (quad_i)           state_d = SQ_SQR;
          else if (is_attack_w) state_d = SQ_OUT;
          else                  state_d = SQ_SCALE;
        end
      end
      SQ_SQR:   if (md_done_i) state_d = is_attack_w ? SQ_OUT : SQ_SCALE;
      SQ_SCALE: if (md_done_i) state_d = SQ_OUT;
      SQ_OUT:   if (out_free_w) state_d = SQ_IDLE;
      default:  state_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    ramp_p_w  = (phase_q == PH_RELEASE) ? LEVEL_FULL - md_quot_i : md_quot_i;
    scale_a_w = (phase_q == PH_RELEASE) ? OP_W'(held_q) : OP_W'(LEVEL_FULL - sustain_i);
    md_start_o   = 1'b0;
    md_by_full_o = 1'b1;
    md_a_o       = scale_a_w;
    md_b_o       = md_quot_i;
    md_den_o     = OP_W'(seg_len_w);
    lvl_we_w     = 1'b0;
    lvl_d        = md_quot_i;
    unique case (state_q)
      SQ_EVAL: begin
        md_start_o   = ramp_w;
        md_by_full_o = 1'b0;
        md_a_o       = (is_attack_w && quad_i) ? OP_W'(seg_len_w - elapsed_q)
                                               : OP_W'(elapsed_q);
        md_b_o       = LEVEL_FULL;
        lvl_we_w     = 1'b1;
        lvl_d        = eval_lvl_w;
      end
      SQ_RAMP: begin
        md_start_o = md_done_i && (quad_i || !is_attack_w);
        md_a_o     = quad_i ? OP_W'(ramp_p_w) : scale_a_w;
        md_b_o     = ramp_p_w;
        lvl_we_w   = md_done_i && is_attack_w && !quad_i;
      end
      SQ_SQR: begin
        md_start_o = md_done_i && !is_attack_w;
        lvl_we_w   = md_done_i && is_attack_w;
        lvl_d      = LEVEL_FULL - md_quot_i;
      end
      SQ_SCALE: begin
        lvl_we_w = md_done_i;
        lvl_d    = (phase_q == PH_RELEASE) ? md_quot_i : LEVEL_FULL - md_quot_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      phase_q     <= PH_IDLE;
      elapsed_q   <= '0;
      held_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept_w) begin
        phase_q <= in_phase_w;
        if (in_zero_w) elapsed_q <= '0;
      end
      if (state_q == SQ_EVAL) begin
        phase_q <= eval_phase_w;
        if (eval_phase_w != phase_q) elapsed_q <= '0;
      end
      if (state_q == SQ_OUT && out_free_w) begin
        out_valid_q <= 1'b1;
        last_q      <= lvl_q;
        if (held_we_q) held_q <= lvl_q;
        if (elapsed_q != '1) elapsed_q <= elapsed_q + TIME_BITS'(1);
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we_w) lvl_q <= lvl_d;
    if (state_q == SQ_EVAL) held_we_q <= (phase_q != PH_RELEASE) && (phase_q != PH_IDLE);
    if (state_q == SQ_OUT && out_free_w) begin
      out_word_q.level <= lvl_q;
      out_word_q.phase <= phase_q;
    end
  end

  assign in_stall_o  = state_q != SQ_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- design/ahdsr_envelope_generator.sv -----
// AHDSR envelope generator top level: configuration registers, sequencer and
// shared multiply-divide unit. Depends on ahdsr_pkg, ahdsr_seq, ahdsr_muldiv.
// Per word: a flat tick goes straight to the output; a ramp runs one 16-step divide,
// then a full-scale square for a quadratic curve and a scale for decay or release.
// Throughput: one word at a time, next accept in the cycle after the output registers.
// Reset is asynchronous, active low: phase idle, elapsed counter, held levels and segment times zero, sustain full.
`timescale 1ns / 1ps
module ahdsr_envelope_generator
  import ahdsr_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned OP_W = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W;

  logic [TIME_BITS-1:0] attack_q, hold_q, decay_q, release_q;
  logic [LEVEL_W-1:0]   sustain_q;
  logic                 quad_q;

  logic                 md_start, md_by_full, md_done;
  logic [OP_W-1:0]      md_a, md_den;
  logic [LEVEL_W-1:0]   md_b, md_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      hold_q    <= '0;
      decay_q   <= '0;
      sustain_q <= LEVEL_FULL;
      release_q <= '0;
      quad_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK:  attack_q  <= TIME_BITS'(cfg_data_i);
        CFG_HOLD:    hold_q    <= TIME_BITS'(cfg_data_i);
        CFG_DECAY:   decay_q   <= TIME_BITS'(cfg_data_i);
        CFG_SUSTAIN: sustain_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_RELEASE: release_q <= TIME_BITS'(cfg_data_i);
        CFG_CURVE:   quad_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ahdsr_seq #(
    .TIME_BITS (TIME_BITS),
    .OP_W      (OP_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o),
    .attack_i     (attack_q),
    .hold_i       (hold_q),
    .decay_i      (decay_q),
    .release_i    (release_q),
    .sustain_i    (sustain_q),
    .quad_i       (quad_q),
    .md_start_o   (md_start),
    .md_by_full_o (md_by_full),
    .md_a_o       (md_a),
    .md_b_o       (md_b),
    .md_den_o     (md_den),
    .md_done_i    (md_done),
    .md_quot_i    (md_quot)
  );

  ahdsr_muldiv #(
    .OP_W (OP_W)
  ) u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .by_full_i (md_by_full),
    .a_i       (md_a),
    .b_i       (md_b),
    .den_i     (md_den),
    .done_o    (md_done),
    .quot_o    (md_quot)
  );

endmodule

// ----- sim/ahdsr_envelope_checker.sv -----
// Scoreboard for ahdsr_envelope_generator: mirrors register writes, predicts each
// output word from the accepted input words and compares. Depends on ahdsr_pkg.
`timescale 1ns / 1ps
module ahdsr_envelope_checker
  import ahdsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    due_count_o
);

  localparam logic [63:0] FULL       = 64'(LEVEL_FULL);
  localparam logic [23:0] TICK_MAX   = '1;

  logic [23:0] attack_len, hold_len, decay_len, release_len;
  logic [15:0] sustain_lvl;
  logic        quadratic;

  phase_e      env_ph;
  logic [23:0] elapsed;
  logic [15:0] held_lvl, prev_lvl;

  out_word_t   pending_words[$];
  out_word_t   want;
  int          mismatches;

  function automatic logic [63:0] ratio(input logic [63:0] num, input logic [63:0] den);
    return (num * FULL) / den;
  endfunction

  function automatic logic [63:0] squared(input logic [63:0] p);
    return (p * p) / FULL;
  endfunction

  function automatic out_word_t next_envelope(input in_word_t w);
    logic [63:0] e, lvl, p, s, dur;
    out_word_t   res;
    s = 64'(sustain_lvl);
    if (w.start_note) begin
      env_ph  = PH_ATTACK;
      elapsed = '0;
    end
    if (w.key_released && env_ph != PH_RELEASE && env_ph != PH_IDLE) begin
      env_ph  = PH_RELEASE;
      elapsed = '0;
    end
    e   = 64'(elapsed);
    lvl = 64'(prev_lvl);
    case (env_ph)
      PH_ATTACK: begin
        dur = 64'(attack_len);
        if (dur == 0 || e > dur) begin
          env_ph  = PH_HOLD;
          elapsed = '0;
          lvl     = FULL;
        end else if (quadratic) begin
          lvl = FULL - squared(ratio(dur - e, dur));
        end else begin
          lvl = ratio(e, dur);
        end
        held_lvl = lvl[15:0];
      end
      PH_HOLD: begin
        lvl      = FULL;
        held_lvl = lvl[15:0];
        if (hold_len == '0 || e > 64'(hold_len)) begin
          env_ph  = PH_DECAY;
          elapsed = '0;
        end
      end
      PH_DECAY: begin
        dur = 64'(decay_len);
        if (dur == 0 || e > dur) begin
          env_ph  = PH_SUSTAIN;
          elapsed = '0;
          lvl     = s;
        end else begin
          p = ratio(e, dur);
          if (quadratic) p = squared(p);
          lvl = FULL - ((FULL - s) * p) / FULL;
        end
        held_lvl = lvl[15:0];
      end
      PH_SUSTAIN: begin
        lvl      = s;
        held_lvl = lvl[15:0];
      end
      PH_RELEASE: begin
        dur = 64'(release_len);
        if (dur == 0 || e > dur) begin
          env_ph  = PH_IDLE;
          elapsed = '0;
        end else begin
          p = FULL - ratio(e, dur);
          if (quadratic) p = squared(p);
          lvl = (64'(held_lvl) * p) / FULL;
        end
      end
      default: env_ph = PH_IDLE;
    endcase
    if (elapsed != TICK_MAX) elapsed = elapsed + 24'd1;
    prev_lvl  = lvl[15:0];
    res.level = lvl[15:0];
    res.phase = env_ph;
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] exp_val,
                            input logic [15:0] got_val);
    mismatches++;
    $display("%0t ns: %s expected %0d got %0d", $time, field, exp_val, got_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len  = '0;
      hold_len    = '0;
      decay_len   = '0;
      release_len = '0;
      sustain_lvl = 16'hFFFF;
      quadratic   = 1'b0;
      env_ph      = PH_IDLE;
      elapsed     = '0;
      held_lvl    = '0;
      prev_lvl    = '0;
      mismatches  = 0;
      pending_words.delete();
      fail_count_o <= 0;
      due_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ATTACK:  attack_len  = cfg_data_i[23:0];
          CFG_HOLD:    hold_len    = cfg_data_i[23:0];
          CFG_DECAY:   decay_len   = cfg_data_i[23:0];
          CFG_SUSTAIN: sustain_lvl = cfg_data_i[15:0];
          CFG_RELEASE: release_len = cfg_data_i[23:0];
          CFG_CURVE:   quadratic   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected word, expected none got level %0d phase %0d",
                   $time, out_word_i.level, out_word_i.phase);
        end else begin
          want = pending_words.pop_front();
          if (out_word_i.level !== want.level)
            flag_field("level", want.level, out_word_i.level);
          if (out_word_i.phase !== want.phase)
            flag_field("phase", 16'(want.phase), 16'(out_word_i.phase));
        end
      end
      if (in_valid_i && !in_stall_i) pending_words.push_back(next_envelope(in_word_i));
      fail_count_o <= mismatches;
      due_count_o  <= pending_words.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the ahdsr_envelope_generator bench: clock, reset, note and register
// stimulus, output stall pattern and verdict. Depends on ahdsr_pkg and the checker.
`timescale 1ns / 1ps
module testbench;
  import ahdsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_WORDS    = 90;
  localparam int PHASE_COUNT    = 8;
  localparam int SETTLE_CYCLES  = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_word_t             out_word_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          fail_count;
  int          due_count;
  int          words_sent  = 0;
  int          idle_cycles = 0;
  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  logic [23:0] attack_len, hold_len, decay_len, release_len;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ahdsr_envelope_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  ahdsr_envelope_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] rand_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 24'($urandom);
    return 24'($urandom_range(1, 12));
  endfunction

  task automatic send_word(input logic start, input logic rel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{start_note: start, key_released: rel};
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_envelope(input logic [23:0] a, input logic [23:0] h,
                              input logic [23:0] d, input logic [23:0] s,
                              input logic [23:0] r, input logic [23:0] c);
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_HOLD, h);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_SUSTAIN, s);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_CURVE, c);
    cfg_we_i    <= 1'b0;
    attack_len  = a;
    hold_len    = h;
    decay_len   = d;
    release_len = r;
  endtask

  // start, held body, key release tail, then a few idle ticks
  task automatic play_note();
    int span, body, tail;
    span = int'(attack_len) + int'(hold_len) + int'(decay_len) + 6;
    if (span > 40) span = 40;
    body = $urandom_range(0, span);
    tail = $urandom_range(1, (release_len > 26) ? 30 : int'(release_len) + 4);
    send_word(1'b1, 1'b0);
    repeat (body) send_word(1'b0, 1'b0);
    repeat (tail) send_word(1'b0, 1'b1);
    repeat ($urandom_range(0, 3)) send_word(1'b0, 1'b0);
  endtask

  task automatic play_noise();
    repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) drain();
  endtask

  initial begin
    int phase_end;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_ATTACK;
    cfg_data_i  <= '0;
    attack_len  = '0;
    hold_len    = '0;
    decay_len   = '0;
    release_len = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every segment skipped
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    repeat (3) send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);

    drain();
    set_envelope(24'd2, 24'd1, 24'd2, 24'h4000, 24'd2, 24'd0);
    send_word(1'b1, 1'b0);
    repeat (9) send_word(1'b0, 1'b0);
    repeat (4) send_word(1'b0, 1'b1);

    drain();
    set_envelope('1, '1, '1, '0, '1, 24'd1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    repeat (2) send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b1);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      quiet = (ph == 2 || ph == 5);
      case (ph)
        0: set_envelope('0, '0, '0, 24'($urandom), '0, 24'($urandom));
        1: set_envelope('1, '1, '1, '0, '1, 24'd1);
        2: set_envelope(24'($urandom_range(1, 3)), 24'($urandom_range(1, 3)),
                        24'($urandom_range(1, 3)), 24'hFFFF,
                        24'($urandom_range(1, 3)), 24'd0);
        default: set_envelope(rand_ticks(), rand_ticks(), rand_ticks(), 24'($urandom),
                              rand_ticks(), 24'($urandom));
      endcase
      if (ph == 3) hold_req = 1'b1;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8) play_note();
        else play_noise();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("ahdsr_envelope_generator verification clean");
    end else begin
      $display("ahdsr_envelope_generator verification failed");
    end
    $finish;
  end

  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ahdsr_envelope_generator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
